// ===== rtl/lfh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the HDLC link frame handler.
// No dependencies; the front end, back end, top and bench import this package.
package lfh_pkg;

   localparam int MAX_INFO_LEN = 4096;
   localparam int LEN_W        = 12;
   localparam int SEQ_W        = 3;
   localparam logic [SEQ_W-1:0] SEQ_MASK = 3'h7;
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = 1;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDR     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTNER_ADDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LIMIT = 2'd2;

   // U frame control codes with P/F masked off
   localparam logic [7:0] U_SABM  = 8'h2F;
   localparam logic [7:0] U_DISC  = 8'h43;
   localparam logic [7:0] U_UA    = 8'h63;
   localparam logic [7:0] U_DM    = 8'h0F;
   localparam logic [7:0] U_FRMR  = 8'h87;
   localparam logic [7:0] U_UI    = 8'h03;
   localparam logic [7:0] U_TEST  = 8'hE3;
   localparam logic [7:0] U_SNRM  = 8'h83;
   localparam logic [7:0] U_SABME = 8'h6F;
   localparam logic [7:0] U_SNRME = 8'hCF;
   localparam logic [7:0] U_SARME = 8'h4F;
   localparam logic [7:0] U_PF_MASK = 8'hEF;

   localparam logic [1:0] S_RR   = 2'd0;
   localparam logic [1:0] S_RNR  = 2'd1;
   localparam logic [1:0] S_REJ  = 2'd2;

   typedef enum logic [3:0] {
      ACT_UA       = 4'd0,
      ACT_DM       = 4'd1,
      ACT_RR       = 4'd2,
      ACT_RNR      = 4'd3,
      ACT_REJ      = 4'd4,
      ACT_FRMR     = 4'd5,
      ACT_RETX     = 4'd6,
      ACT_TEST     = 4'd7,
      ACT_DELIVER  = 4'd8,
      ACT_EVENT    = 4'd9,
      ACT_T1_START = 4'd10,
      ACT_T1_STOP  = 4'd11,
      ACT_T2_START = 4'd12,
      ACT_T2_STOP  = 4'd13,
      ACT_T3_START = 4'd14,
      ACT_T3_STOP  = 4'd15
   } action_type;

   localparam logic [3:0] EV_IN_CONNECT  = 4'd0;
   localparam logic [3:0] EV_ACCEPTED    = 4'd1;
   localparam logic [3:0] EV_PEER_REJECT = 4'd2;
   localparam logic [3:0] EV_PEER_DISC   = 4'd3;
   localparam logic [3:0] EV_DISC_DONE   = 4'd4;
   localparam logic [3:0] EV_PROTO_ERR   = 4'd5;
   localparam logic [3:0] EV_WINDOW_OPEN = 4'd6;
   localparam logic [3:0] EV_BUSY_ON     = 4'd7;
   localparam logic [3:0] EV_BUSY_OFF    = 4'd8;

   localparam logic [3:0] FRMR_W = 4'h8;
   localparam logic [3:0] FRMR_Z = 4'h1;

   typedef enum logic [2:0] {
      MODE_DISC          = 3'd0,
      MODE_CONNECTING    = 3'd1,
      MODE_DISCONNECTING = 3'd2,
      MODE_CONNECTED     = 3'd3,
      MODE_FRMR          = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      UC_SABM, UC_SABME, UC_MODE, UC_DISC, UC_UA, UC_DM,
      UC_FRMR, UC_UI, UC_TEST, UC_OTHER
   } ucls_type;

   // Decoded received word, as held in the queue
   typedef struct packed {
      logic             is_i;
      logic             is_s;
      logic             is_u;
      ucls_type         ucls;
      logic [1:0]       kind;
      logic             pf;
      logic [SEQ_W-1:0] ns;
      logic [SEQ_W-1:0] nr;
      logic             cmd;
      logic [7:0]       ctrl;
      logic [LEN_W-1:0] len;
      logic             lbusy;
      logic             t2run;
      logic             t3run;
   } frame_type;

   // Action slots in the order they are emitted
   localparam int OP_W = 5;
   localparam int N_OPS = 23;
   localparam logic [OP_W-1:0] OP_T3STOP   = 5'd0;
   localparam logic [OP_W-1:0] OP_T3RESTRT = 5'd1;
   localparam logic [OP_W-1:0] OP_T1PRE    = 5'd2;
   localparam logic [OP_W-1:0] OP_BUSYEV   = 5'd3;
   localparam logic [OP_W-1:0] OP_WINEV    = 5'd4;
   localparam logic [OP_W-1:0] OP_T1NR     = 5'd5;
   localparam logic [OP_W-1:0] OP_RST1     = 5'd6;
   localparam logic [OP_W-1:0] OP_RST2     = 5'd7;
   localparam logic [OP_W-1:0] OP_RST3     = 5'd8;
   localparam logic [OP_W-1:0] OP_UFRAME   = 5'd9;
   localparam logic [OP_W-1:0] OP_DELIV    = 5'd10;
   localparam logic [OP_W-1:0] OP_RETX1    = 5'd11;
   localparam logic [OP_W-1:0] OP_T1S1     = 5'd12;
   localparam logic [OP_W-1:0] OP_RESP     = 5'd13;
   localparam logic [OP_W-1:0] OP_T2OP     = 5'd14;
   localparam logic [OP_W-1:0] OP_RETX2    = 5'd15;
   localparam logic [OP_W-1:0] OP_T1S2     = 5'd16;
   localparam logic [OP_W-1:0] OP_STEV     = 5'd17;
   localparam logic [OP_W-1:0] OP_T3POST   = 5'd18;
   localparam logic [OP_W-1:0] OP_FRMR     = 5'd19;
   localparam logic [OP_W-1:0] OP_FRMR_T1  = 5'd20;
   localparam logic [OP_W-1:0] OP_FRMR_T2  = 5'd21;
   localparam logic [OP_W-1:0] OP_FRMR_EV  = 5'd22;

   typedef struct packed {
      action_type       uf_act;
      logic             uf_pf;
      action_type       dl_act;
      logic             dl_pf;
      logic [LEN_W-1:0] dl_len;
      action_type       rs_act;
      logic             rs_pf;
      action_type       t2_act;
      action_type       t1_act;
      logic [3:0]       busy_ev;
      logic [3:0]       st_ev;
      mode_type         st_mode;
      logic [3:0]       fr_flags;
      logic [7:0]       fr_ctrl;
      logic [SEQ_W-1:0] fr_ns;
      logic [SEQ_W-1:0] fr_nr;
      logic [SEQ_W-1:0] recv;
      logic [SEQ_W-1:0] retx_start;
      logic [SEQ_W-1:0] retx_end;
   } plan_type;

   typedef struct packed {
      action_type       action;
      logic             poll_final;
      logic [SEQ_W-1:0] send_seq;
      logic [SEQ_W-1:0] recv_seq;
      logic [7:0]       rejected_control;
      logic [3:0]       frmr_flags;
      logic [3:0]       event_code;
      mode_type         link_mode;
      logic [LEN_W-1:0] payload_length;
      logic             last_action;
   } result_type;

endpackage

// ===== rtl/lfh_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received headers and emitted actions.
// No dependencies.
interface lfh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_address;
   logic [7:0]  control_byte;
   logic [11:0] info_length;
   logic        local_busy_flag;
   logic        t2_running;
   logic        t3_running;
   modport source (output valid, frame_address, control_byte, info_length,
                   local_busy_flag, t2_running, t3_running, input ready);
   modport sink (input valid, frame_address, control_byte, info_length,
                 local_busy_flag, t2_running, t3_running, output ready);
endinterface

interface lfh_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic        poll_final;
   logic [2:0]  send_seq;
   logic [2:0]  recv_seq;
   logic [7:0]  rejected_control;
   logic [3:0]  frmr_flags;
   logic [3:0]  event_code;
   logic [2:0]  link_mode;
   logic [11:0] payload_length;
   logic        last_action;
   modport source (output valid, action, poll_final, send_seq, recv_seq,
                   rejected_control, frmr_flags, event_code, link_mode,
                   payload_length, last_action, input ready);
   modport sink (input valid, action, poll_final, send_seq, recv_seq,
                 rejected_control, frmr_flags, event_code, link_mode,
                 payload_length, last_action, output ready);
endinterface

// ===== rtl/lfh_front.sv =====
`timescale 1ns / 1ps
// Front end: decodes each received header word and queues it for the back end.
// Depends on lfh_pkg and lfh_req_if.
module lfh_front
   import lfh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   own_address,
   lfh_req_if.sink      req_chan,
   output logic         q_valid,
   output frame_type    q_frame,
   input  logic         q_pop
);

   frame_type            dec;
   frame_type            q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      cnt_ff, cnt_in;
   logic                 push;
   logic [7:0]           u;

   always_comb begin
      u        = req_chan.control_byte & U_PF_MASK;
      dec.ctrl = req_chan.control_byte;
      dec.is_i = ~req_chan.control_byte[0];
      dec.is_s = (req_chan.control_byte[1:0] == 2'b01);
      dec.is_u = (req_chan.control_byte[1:0] == 2'b11);
      dec.kind = req_chan.control_byte[3:2];
      dec.pf   = req_chan.control_byte[4];
      dec.ns   = req_chan.control_byte[3:1];
      dec.nr   = req_chan.control_byte[7:5];
      dec.cmd  = (req_chan.frame_address == own_address);
      dec.len  = req_chan.info_length;
      dec.lbusy = req_chan.local_busy_flag;
      dec.t2run = req_chan.t2_running;
      dec.t3run = req_chan.t3_running;
      unique case (u)
         U_SABM:  dec.ucls = UC_SABM;
         U_SABME: dec.ucls = UC_SABME;
         U_SNRM, U_SNRME, U_SARME: dec.ucls = UC_MODE;
         U_DISC:  dec.ucls = UC_DISC;
         U_UA:    dec.ucls = UC_UA;
         U_DM:    dec.ucls = UC_DM;
         U_FRMR:  dec.ucls = UC_FRMR;
         U_UI:    dec.ucls = UC_UI;
         U_TEST:  dec.ucls = UC_TEST;
         default: dec.ucls = UC_OTHER;
      endcase
   end

   assign req_chan.ready = (cnt_ff != (QPTR_W+1)'(QDEPTH));
   assign push    = req_chan.valid & req_chan.ready;
   assign q_valid = (cnt_ff != '0);
   assign q_frame = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/lfh_back.sv =====
`timescale 1ns / 1ps
// Back end: runs the link state machine on one queued word and emits its actions.
// Depends on lfh_pkg and lfh_rsp_if.
module lfh_back
   import lfh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   own_address,
   input  logic [7:0]   partner_address,
   input  logic [2:0]   window_limit,
   input  logic         q_valid,
   input  frame_type    q_frame,
   output logic         q_pop,
   lfh_rsp_if.source    rsp_chan
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } bk_state_type;

   bk_state_type       st_ff, st_in;
   mode_type           link_ff, link_in;
   logic [SEQ_W-1:0]   send_ff, send_in, ack_ff, ack_in, recv_ff, recv_in;
   logic               rp_ff, rp_in, pb_ff, pb_in;
   logic [N_OPS-1:0]   mask_ff, mask_in, mask;
   plan_type           plan_ff, plan_in, p;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   result_type         rsp_ff, rsp_in, res;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SEQ_W-1:0]   n_send, n_ack, n_recv, dn, dv, ackn;
   logic               n_rp, n_pb, use_nr, nr_bad, rp_after;
   logic [OP_W-1:0]    op;
   logic               out_free, emit, op_done, is_last;
   logic [N_OPS-1:0]   mask_rest;
   frame_type          f;

   // ---------------- dispatch: plan the whole run from one word --------------
   always_comb begin
      f      = q_frame;
      mask   = '0;
      p      = '0;
      n_send = send_ff;
      n_ack  = ack_ff;
      n_recv = recv_ff;
      n_rp   = rp_ff;
      n_pb   = pb_ff;
      use_nr = 1'b0;
      dn     = (f.nr - ack_ff) & SEQ_MASK;
      dv     = (send_ff - ack_ff) & SEQ_MASK;
      nr_bad = (dn > dv);
      rp_after = (f.nr != ack_ff) ? 1'b0 : rp_ff;
      ackn   = ack_ff;
      p.dl_len = ({1'b0, f.len} > (LEN_W+1)'(MAX_INFO_LEN)) ? LEN_W'(MAX_INFO_LEN) : f.len;
      p.uf_act = ACT_UA;
      p.dl_act = ACT_DELIVER;
      p.rs_act = ACT_RR;
      p.t2_act = ACT_T2_STOP;
      p.t1_act = ACT_T1_START;
      p.st_mode = MODE_DISC;
      p.fr_ctrl = f.ctrl;
      p.fr_ns   = send_ff;
      p.fr_nr   = recv_ff;
      p.retx_end = send_ff;

      if (link_ff == MODE_CONNECTED && f.t3run) begin
         mask[OP_T3STOP]   = 1'b1;
         mask[OP_T3RESTRT] = 1'b1;
      end

      case (link_ff)
         MODE_DISC: begin
            if (f.is_u) begin
               case (f.ucls)
                  UC_SABM: begin
                     mask[OP_RST1] = 1'b1; mask[OP_RST2] = 1'b1; mask[OP_RST3] = 1'b1;
                     mask[OP_UFRAME] = 1'b1; p.uf_pf = f.pf;
                     mask[OP_STEV] = 1'b1; p.st_ev = EV_IN_CONNECT;
                     p.st_mode = MODE_CONNECTED;
                     mask[OP_T3POST] = 1'b1;
                  end
                  UC_DISC: begin
                     mask[OP_UFRAME] = 1'b1; p.uf_pf = f.pf;
                  end
                  UC_UI: mask[OP_DELIV] = 1'b1;
                  UC_SABME, UC_MODE: begin
                     mask[OP_UFRAME] = 1'b1; p.uf_act = ACT_DM; p.uf_pf = f.pf;
                  end
                  default: ;
               endcase
            end
         end
         MODE_CONNECTING: begin
            if (f.is_u) begin
               case (f.ucls)
                  UC_SABM: begin
                     // contention: the peer's SABM is taken unless the partner address is the higher one
                     if (!(partner_address > own_address)) begin
                        mask[OP_RST1] = 1'b1; mask[OP_RST2] = 1'b1;
                        mask[OP_RST3] = 1'b1;
                        mask[OP_UFRAME] = 1'b1; p.uf_pf = f.pf;
                        mask[OP_STEV] = 1'b1; p.st_ev = EV_IN_CONNECT;
                        p.st_mode = MODE_CONNECTED;
                        mask[OP_T3POST] = 1'b1;
                     end
                  end
                  UC_UA: begin
                     if (f.pf) begin
                        mask[OP_T1PRE] = 1'b1;
                        mask[OP_RST1] = 1'b1; mask[OP_RST2] = 1'b1;
                        mask[OP_RST3] = 1'b1;
                        mask[OP_STEV] = 1'b1; p.st_ev = EV_ACCEPTED;
                        p.st_mode = MODE_CONNECTED;
                        mask[OP_T3POST] = 1'b1;
                     end
                  end
                  UC_DM: begin
                     if (f.pf) begin
                        mask[OP_T1PRE] = 1'b1;
                        mask[OP_STEV] = 1'b1; p.st_ev = EV_PEER_REJECT;
                     end
                  end
                  UC_DISC: begin
                     mask[OP_UFRAME] = 1'b1; p.uf_act = ACT_DM; p.uf_pf = f.pf;
                  end
                  default: ;
               endcase
            end
         end
         MODE_DISCONNECTING: begin
            if (!f.is_u) begin
               if (f.pf) begin
                  mask[OP_UFRAME] = 1'b1; p.uf_act = ACT_DM; p.uf_pf = 1'b1;
               end
            end else begin
               case (f.ucls)
                  UC_SABM, UC_SABME: begin
                     mask[OP_UFRAME] = 1'b1; p.uf_act = ACT_DM; p.uf_pf = f.pf;
                  end
                  UC_DISC: begin
                     mask[OP_UFRAME] = 1'b1; p.uf_pf = f.pf;
                  end
                  UC_UA: begin
                     if (f.pf) begin
                        mask[OP_T1PRE] = 1'b1;
                        mask[OP_STEV] = 1'b1; p.st_ev = EV_DISC_DONE;
                     end
                  end
                  UC_DM: begin
                     if (f.pf) begin
                        mask[OP_T1PRE] = 1'b1;
                        mask[OP_STEV] = 1'b1; p.st_ev = EV_PEER_REJECT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         MODE_CONNECTED: begin
            if (f.is_i) begin
               use_nr = 1'b1;
            end else if (f.is_s) begin
               case (f.kind)
                  S_RR: begin
                     if (pb_ff) begin
                        n_pb = 1'b0; mask[OP_BUSYEV] = 1'b1; p.busy_ev = EV_BUSY_OFF;
                     end
                     use_nr = 1'b1;
                  end
                  S_RNR: begin
                     if (!pb_ff) begin
                        n_pb = 1'b1; mask[OP_BUSYEV] = 1'b1; p.busy_ev = EV_BUSY_ON;
                     end
                     use_nr = 1'b1;
                  end
                  S_REJ: begin
                     n_pb = 1'b0;
                     use_nr = 1'b1;
                  end
                  default: ;
               endcase
            end

            if (use_nr && nr_bad) begin
               mask[OP_FRMR] = 1'b1; mask[OP_FRMR_T1] = 1'b1;
               mask[OP_FRMR_T2] = 1'b1; mask[OP_FRMR_EV] = 1'b1;
               p.fr_flags = FRMR_Z;
            end else if (f.is_u) begin
               case (f.ucls)
                  UC_SABM, UC_DISC, UC_DM, UC_FRMR: begin
                     mask[OP_RST1] = 1'b1; mask[OP_RST2] = 1'b1; mask[OP_RST3] = 1'b1;
                     n_send = '0; n_ack = '0; n_recv = '0; n_rp = 1'b0; n_pb = 1'b0;
                     if (f.ucls == UC_SABM || f.ucls == UC_DISC) begin
                        mask[OP_UFRAME] = 1'b1; p.uf_pf = f.pf;
                     end
                     if (f.ucls != UC_SABM) begin
                        mask[OP_STEV] = 1'b1;
                     end
                     if (f.ucls == UC_DISC) begin
                        p.st_ev = EV_PEER_DISC;
                     end else if (f.ucls == UC_DM) begin
                        p.st_ev = EV_PEER_REJECT;
                     end else begin
                        p.st_ev = EV_PROTO_ERR;
                        p.st_mode = MODE_FRMR;
                     end
                  end
                  UC_UI: mask[OP_DELIV] = 1'b1;
                  UC_TEST: begin
                     mask[OP_DELIV] = 1'b1;
                     if (f.cmd) begin
                        p.dl_act = ACT_TEST; p.dl_pf = f.pf;
                     end
                  end
                  UC_SABME, UC_MODE: begin
                     mask[OP_UFRAME] = 1'b1; p.uf_act = ACT_DM; p.uf_pf = f.pf;
                  end
                  default: begin
                     mask[OP_FRMR] = 1'b1; mask[OP_FRMR_T1] = 1'b1;
                     mask[OP_FRMR_T2] = 1'b1; mask[OP_FRMR_EV] = 1'b1;
                     p.fr_flags = FRMR_W;
                  end
               endcase
            end else begin
               if (use_nr) begin
                  ackn = f.nr;
                  if (f.nr != ack_ff) begin
                     n_ack = f.nr;
                     n_rp  = 1'b0;
                     if (dv >= window_limit) mask[OP_WINEV] = 1'b1;
                  end
                  mask[OP_T1NR] = 1'b1;
                  p.t1_act = (f.nr == send_ff) ? ACT_T1_STOP : ACT_T1_START;
               end
               if (f.is_i) begin
                  if (f.ns == recv_ff) begin
                     n_recv = recv_ff + 1'b1;
                     n_rp   = 1'b0;
                     mask[OP_DELIV] = 1'b1;
                     if (f.pf) begin
                        mask[OP_RESP] = 1'b1; p.rs_pf = 1'b1;
                        p.rs_act = f.lbusy ? ACT_RNR : ACT_RR;
                        mask[OP_T2OP] = 1'b1;
                     end else if (!f.t2run) begin
                        if (f.lbusy) begin
                           mask[OP_RESP] = 1'b1; p.rs_act = ACT_RNR;
                        end else begin
                           mask[OP_T2OP] = 1'b1; p.t2_act = ACT_T2_START;
                        end
                     end
                  end else if (rp_after) begin
                     if (f.pf) begin
                        mask[OP_RESP] = 1'b1; p.rs_pf = 1'b1;
                     end
                  end else begin
                     n_rp = 1'b1;
                     mask[OP_RESP] = 1'b1; p.rs_act = ACT_REJ; p.rs_pf = f.pf;
                     mask[OP_T2OP] = 1'b1;
                  end
               end else if (f.is_s) begin
                  if (f.kind == S_REJ && !rp_after && f.nr != send_ff) begin
                     n_rp = 1'b1;
                     mask[OP_RETX1] = 1'b1; mask[OP_T1S1] = 1'b1;
                  end
                  if (f.pf) begin
                     if (f.cmd) begin
                        mask[OP_RESP] = 1'b1; p.rs_pf = 1'b1;
                     end else if (ackn != send_ff) begin
                        mask[OP_RETX2] = 1'b1; mask[OP_T1S2] = 1'b1;
                     end
                  end
               end
            end
         end
         MODE_FRMR: begin
            if (f.is_u && f.ucls == UC_SABM) begin
               mask[OP_RST1] = 1'b1; mask[OP_RST2] = 1'b1; mask[OP_RST3] = 1'b1;
               mask[OP_UFRAME] = 1'b1; p.uf_pf = f.pf;
               mask[OP_STEV] = 1'b1; p.st_ev = EV_IN_CONNECT;
               p.st_mode = MODE_CONNECTED;
               mask[OP_T3POST] = 1'b1;
            end
         end
         default: mask = '0;
      endcase

      // a link reset outside the connected branch clears the variables too
      if (mask[OP_RST1]) begin
         n_send = '0; n_ack = '0; n_recv = '0; n_rp = 1'b0; n_pb = 1'b0;
      end
      p.recv       = n_recv;
      p.retx_start = ackn;
   end

   // emission of one action per cycle, while the output register is empty or being taken
   always_comb begin
      op = '0;
      for (int i = N_OPS - 1; i >= 0; i--) begin
         if (mask_ff[i]) op = OP_W'(i);
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;
   assign emit     = (st_ff == BK_RUN) & out_free;
   assign op_done  = ((op != OP_RETX1) && (op != OP_RETX2)) ||
                     ((seq_ff + 1'b1) == plan_ff.retx_end);

   always_comb begin
      mask_rest     = mask_ff;
      mask_rest[op] = 1'b0;
      is_last       = op_done & (mask_rest == '0);
   end

   always_comb begin
      res = '0;
      res.link_mode   = link_ff;
      res.last_action = is_last;
      res.action      = ACT_T1_STOP;
      unique case (op)
         OP_T3STOP:   res.action = ACT_T3_STOP;
         OP_T3RESTRT: res.action = ACT_T3_START;
         OP_T1PRE:    res.action = ACT_T1_STOP;
         OP_BUSYEV: begin
            res.action = ACT_EVENT; res.event_code = plan_ff.busy_ev;
         end
         OP_WINEV: begin
            res.action = ACT_EVENT; res.event_code = EV_WINDOW_OPEN;
         end
         OP_T1NR:     res.action = plan_ff.t1_act;
         OP_RST1:     res.action = ACT_T1_STOP;
         OP_RST2:     res.action = ACT_T2_STOP;
         OP_RST3:     res.action = ACT_T3_STOP;
         OP_UFRAME: begin
            res.action = plan_ff.uf_act; res.poll_final = plan_ff.uf_pf;
         end
         OP_DELIV: begin
            res.action = plan_ff.dl_act; res.poll_final = plan_ff.dl_pf;
            res.payload_length = plan_ff.dl_len;
         end
         OP_RETX1, OP_RETX2: begin
            res.action = ACT_RETX; res.send_seq = seq_ff; res.recv_seq = plan_ff.recv;
         end
         OP_T1S1, OP_T1S2, OP_T3POST: begin
            res.action = (op == OP_T3POST) ? ACT_T3_START : ACT_T1_START;
         end
         OP_RESP: begin
            res.action = plan_ff.rs_act; res.poll_final = plan_ff.rs_pf;
            res.recv_seq = plan_ff.recv;
         end
         OP_T2OP:     res.action = plan_ff.t2_act;
         OP_STEV: begin
            res.action = ACT_EVENT; res.event_code = plan_ff.st_ev;
            res.link_mode = plan_ff.st_mode;
         end
         OP_FRMR: begin
            res.action = ACT_FRMR; res.send_seq = plan_ff.fr_ns;
            res.recv_seq = plan_ff.fr_nr; res.rejected_control = plan_ff.fr_ctrl;
            res.frmr_flags = plan_ff.fr_flags;
         end
         OP_FRMR_T1:  res.action = ACT_T1_STOP;
         OP_FRMR_T2:  res.action = ACT_T2_STOP;
         OP_FRMR_EV: begin
            res.action = ACT_EVENT; res.event_code = EV_PROTO_ERR;
            res.link_mode = MODE_FRMR;
         end
         default:     res.action = ACT_T1_STOP;
      endcase
   end

   // ---------------- sequencing and state update ------------------------------
   assign q_pop = (st_ff == BK_IDLE) & q_valid;

   always_comb begin
      st_in   = st_ff;
      link_in = link_ff;
      send_in = send_ff;
      ack_in  = ack_ff;
      recv_in = recv_ff;
      rp_in   = rp_ff;
      pb_in   = pb_ff;
      mask_in = mask_ff;
      plan_in = plan_ff;
      seq_in  = seq_ff;
      rsp_in  = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      unique case (st_ff)
         BK_IDLE: begin
            if (q_pop) begin
               send_in = n_send;
               ack_in  = n_ack;
               recv_in = n_recv;
               rp_in   = n_rp;
               pb_in   = n_pb;
               mask_in = mask;
               plan_in = p;
               seq_in  = p.retx_start;
               if (mask != '0) st_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (emit) begin
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               link_in      = res.link_mode;
               if (op_done) begin
                  mask_in = mask_rest;
                  seq_in  = plan_ff.retx_start;
               end else begin
                  seq_in  = seq_ff + 1'b1;
               end
               if (is_last) st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         link_ff      <= MODE_DISC;
         send_ff      <= '0;
         ack_ff       <= '0;
         recv_ff      <= '0;
         rp_ff        <= 1'b0;
         pb_ff        <= 1'b0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         link_ff      <= link_in;
         send_ff      <= send_in;
         ack_ff       <= ack_in;
         recv_ff      <= recv_in;
         rp_ff        <= rp_in;
         pb_ff        <= pb_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      seq_ff  <= seq_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.action           = rsp_ff.action;
   assign rsp_chan.poll_final       = rsp_ff.poll_final;
   assign rsp_chan.send_seq         = rsp_ff.send_seq;
   assign rsp_chan.recv_seq         = rsp_ff.recv_seq;
   assign rsp_chan.rejected_control = rsp_ff.rejected_control;
   assign rsp_chan.frmr_flags       = rsp_ff.frmr_flags;
   assign rsp_chan.event_code       = rsp_ff.event_code;
   assign rsp_chan.link_mode        = rsp_ff.link_mode;
   assign rsp_chan.payload_length   = rsp_ff.payload_length;
   assign rsp_chan.last_action      = rsp_ff.last_action;

endmodule

// ===== rtl/hdlc_abm_link_frame_handler.sv =====
`timescale 1ns / 1ps
// HDLC balanced-mode link frame handler, modulo 8: front decoder/queue,
// back-end link state machine, configuration registers.
// Depends on lfh_pkg, lfh_ifs, lfh_front and lfh_back.
//
// req_chan takes one CRC-checked frame header word per received frame;
// rsp_chan returns the run of actions that word causes, one word each,
// with last_action set on the final one (a word may cause no action).
// csr_we/csr_index/csr_wdata write own_address (0), partner_address (1)
// and window_limit (2); write only while the block is idle.
//
// A queued header is planned as the back end pops it and the plan is
// registered; its actions then leave one per cycle through the output
// register while rsp_chan takes them (up to about 20 for a go-back-N burst).
// The back-end sequencer, which walks the planned action slots one per
// cycle, sets that rate. A two-word queue in front keeps taking headers
// while the back end works.
// Reset puts the link in disconnected mode with all sequence variables
// clear and the registers at 1, 3 and 7. When rsp_chan stalls, the
// output word holds and the sequencer waits; the queue then fills and
// req_chan.ready drops.
module hdlc_abm_link_frame_handler
   import lfh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   lfh_req_if.sink               req_chan,
   lfh_rsp_if.source             rsp_chan
);

   logic [7:0]  own_ff, own_in, partner_ff, partner_in;
   logic [2:0]  window_ff, window_in;
   logic        q_valid, q_pop;
   frame_type   q_frame;

   always_comb begin
      own_in     = own_ff;
      partner_in = partner_ff;
      window_in  = window_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDR:     own_in     = csr_wdata;
            CSR_PARTNER_ADDR: partner_in = csr_wdata;
            CSR_WINDOW_LIMIT: window_in  = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff     <= 8'd1;
         partner_ff <= 8'd3;
         window_ff  <= 3'd7;
      end else begin
         own_ff     <= own_in;
         partner_ff <= partner_in;
         window_ff  <= window_in;
      end
   end

   lfh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .own_address (own_ff),
      .req_chan    (req_chan),
      .q_valid     (q_valid),
      .q_frame     (q_frame),
      .q_pop       (q_pop)
   );

   lfh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .own_address     (own_ff),
      .partner_address (partner_ff),
      .window_limit    (window_ff),
      .q_valid         (q_valid),
      .q_frame         (q_frame),
      .q_pop           (q_pop),
      .rsp_chan        (rsp_chan)
   );

endmodule

// ===== dv/tb_hdlc_abm_link_frame_handler.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the HDLC balanced-mode link frame handler: drives frame
// headers, predicts every emitted action word and compares them in order.
// Depends on lfh_pkg, lfh_ifs and the hdlc_abm_link_frame_handler RTL.
module tb_hdlc_abm_link_frame_handler;
   import lfh_pkg::*;

   localparam int MAX_ACTIONS = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;
   localparam logic [7:0] U_XID = 8'hAF;

   typedef struct {
      logic [7:0]  addr;
      logic [7:0]  ctrl;
      logic [11:0] len;
      logic        lbusy;
      logic        t2run;
      logic        t3run;
      int          n_actions;  // -1 when only the predictor decides
      action_type  first_action;
   } header_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lfh_req_if req_bus();
   lfh_rsp_if rsp_bus();

   hdlc_abm_link_frame_handler uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // link state copy and registers
   mode_type   lk_mode;
   logic [2:0] vs, va, vr;
   logic       rej_pend, peer_bsy;
   logic [7:0] own_addr, partner_addr;
   logic [2:0] win_limit;
   logic [7:0] cur_ctrl;
   logic [11:0] cur_len;

   result_type step_actions[$];
   result_type pending_actions[$];
   header_type directed_rows[$];

   int send_idle_pct, recv_idle_pct;
   int fail_count, mismatch_count, words_seen, headers_sent;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_actions.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void put(action_type act, logic pf, logic [2:0] ns, logic [2:0] nr,
                               logic [7:0] rc, logic [3:0] fl, logic [3:0] ev,
                               logic [11:0] len);
      result_type r;
      if (step_actions.size() >= MAX_ACTIONS) return;
      r.action = act;
      r.poll_final = pf;
      r.send_seq = ns;
      r.recv_seq = nr;
      r.rejected_control = rc;
      r.frmr_flags = fl;
      r.event_code = ev;
      r.link_mode = lk_mode;
      r.payload_length = len;
      r.last_action = 1'b0;
      step_actions.push_back(r);
   endfunction

   function automatic void put_plain(action_type act, logic pf);
      put(act, pf, 3'd0, 3'd0, 8'd0, 4'd0, 4'd0, 12'd0);
   endfunction

   function automatic void put_sframe(action_type act, logic pf);
      put(act, pf, 3'd0, vr, 8'd0, 4'd0, 4'd0, 12'd0);
   endfunction

   function automatic void put_event(logic [3:0] ev);
      put(ACT_EVENT, 1'b0, 3'd0, 3'd0, 8'd0, 4'd0, ev, 12'd0);
   endfunction

   function automatic void enter_mode(mode_type m, logic [3:0] ev);
      lk_mode = m;
      put_event(ev);
   endfunction

   function automatic void put_data(action_type act, logic pf);
      put(act, pf, 3'd0, 3'd0, 8'd0, 4'd0, 4'd0, cur_len);
   endfunction

   function automatic void clear_link();
      vs = 3'd0; va = 3'd0; vr = 3'd0;
      rej_pend = 1'b0; peer_bsy = 1'b0;
      put_plain(ACT_T1_STOP, 1'b0);
      put_plain(ACT_T2_STOP, 1'b0);
      put_plain(ACT_T3_STOP, 1'b0);
   endfunction

   function automatic void lock_down(logic [3:0] flags);
      put(ACT_FRMR, 1'b0, vs, vr, cur_ctrl, flags, 4'd0, 12'd0);
      put_plain(ACT_T1_STOP, 1'b0);
      put_plain(ACT_T2_STOP, 1'b0);
      enter_mode(MODE_FRMR, EV_PROTO_ERR);
   endfunction

   // N(R) check and V(A) update; 0 when the link went to FRMR
   function automatic bit ack_update(logic [2:0] nr);
      logic [2:0] dn, dv;
      dn = nr - va;
      dv = vs - va;
      if (dn > dv) begin
         lock_down(FRMR_Z);
         return 1'b0;
      end
      if (nr != va) begin
         va = nr;
         rej_pend = 1'b0;
         if (dv >= win_limit) put_event(EV_WINDOW_OPEN);
      end
      put_plain((va == vs) ? ACT_T1_STOP : ACT_T1_START, 1'b0);
      return 1'b1;
   endfunction

   function automatic void rewind_to(logic [2:0] from);
      logic [2:0] old;
      old = vs;
      if (vs == from) return;
      vs = from;
      while (vs != old) begin
         put(ACT_RETX, 1'b0, vs, vr, 8'd0, 4'd0, 4'd0, 12'd0);
         vs = vs + 3'd1;
      end
      put_plain(ACT_T1_START, 1'b0);
   endfunction

   function automatic void take_sabm(logic pf);
      clear_link();
      put_plain(ACT_UA, pf);
      enter_mode(MODE_CONNECTED, EV_IN_CONNECT);
      put_plain(ACT_T3_START, 1'b0);
   endfunction

   function automatic bit mode_cmd(logic [7:0] u);
      return u == U_SNRM || u == U_SABME || u == U_SNRME || u == U_SARME;
   endfunction

   function automatic void run_connected(logic [7:0] addr, logic lbusy, logic t2run);
      logic [7:0] c, u;
      logic       pf;
      logic [2:0] nr, ns;
      logic [1:0] kind;
      c = cur_ctrl;
      pf = c[4];
      nr = c[7:5];
      ns = c[3:1];
      kind = c[3:2];
      u = c & U_PF_MASK;
      if (!c[0]) begin
         if (!ack_update(nr)) return;
         if (ns == vr) begin
            vr = vr + 3'd1;
            rej_pend = 1'b0;
            put_data(ACT_DELIVER, 1'b0);
            if (pf) begin
               put_sframe(lbusy ? ACT_RNR : ACT_RR, 1'b1);
               put_plain(ACT_T2_STOP, 1'b0);
            end else if (!t2run) begin
               if (lbusy) put_sframe(ACT_RNR, 1'b0);
               else put_plain(ACT_T2_START, 1'b0);
            end
         end else if (rej_pend) begin
            if (pf) put_sframe(ACT_RR, 1'b1);
         end else begin
            rej_pend = 1'b1;
            put_sframe(ACT_REJ, pf);
            put_plain(ACT_T2_STOP, 1'b0);
         end
      end else if (c[1:0] == 2'b01) begin
         if (kind == S_RR) begin
            if (peer_bsy) begin
               peer_bsy = 1'b0;
               put_event(EV_BUSY_OFF);
            end
            if (!ack_update(nr)) return;
         end else if (kind == S_RNR) begin
            if (!peer_bsy) begin
               peer_bsy = 1'b1;
               put_event(EV_BUSY_ON);
            end
            if (!ack_update(nr)) return;
         end else if (kind == S_REJ) begin
            peer_bsy = 1'b0;
            if (!ack_update(nr)) return;
            if (!rej_pend && va != vs) begin
               rej_pend = 1'b1;
               rewind_to(nr);
            end
         end
         if (pf) begin
            if (addr == own_addr) put_sframe(ACT_RR, 1'b1);
            else if (va != vs) rewind_to(va);
         end
      end else begin
         if (u == U_SABM) begin
            clear_link();
            put_plain(ACT_UA, pf);
         end else if (u == U_DISC) begin
            clear_link();
            put_plain(ACT_UA, pf);
            enter_mode(MODE_DISC, EV_PEER_DISC);
         end else if (u == U_DM) begin
            clear_link();
            enter_mode(MODE_DISC, EV_PEER_REJECT);
         end else if (u == U_FRMR) begin
            clear_link();
            enter_mode(MODE_FRMR, EV_PROTO_ERR);
         end else if (u == U_UI) put_data(ACT_DELIVER, 1'b0);
         else if (u == U_TEST) begin
            if (addr == own_addr) put_data(ACT_TEST, pf);
            else put_data(ACT_DELIVER, 1'b0);
         end else if (mode_cmd(u)) put_plain(ACT_DM, pf);
         else lock_down(FRMR_W);
      end
   endfunction

   // runs one header through the link state copy, leaves its actions in step_actions
   function automatic void predict_header(header_type h);
      logic [7:0] u;
      logic       pf, is_u;
      step_actions.delete();
      cur_ctrl = h.ctrl;
      cur_len = h.len;
      pf = h.ctrl[4];
      is_u = (h.ctrl[1:0] == 2'b11);
      u = h.ctrl & U_PF_MASK;
      if (lk_mode == MODE_CONNECTED && h.t3run) begin
         put_plain(ACT_T3_STOP, 1'b0);
         put_plain(ACT_T3_START, 1'b0);
      end
      case (lk_mode)
         MODE_DISC: begin
            if (is_u) begin
               if (u == U_SABM) take_sabm(pf);
               else if (u == U_DISC) put_plain(ACT_UA, pf);
               else if (u == U_UI) put_data(ACT_DELIVER, 1'b0);
               else if (mode_cmd(u)) put_plain(ACT_DM, pf);
            end
         end
         MODE_CONNECTING: begin
            if (is_u) begin
               if (u == U_SABM) begin
                  if (!(partner_addr > own_addr)) take_sabm(pf);
               end else if (u == U_UA) begin
                  if (pf) begin
                     put_plain(ACT_T1_STOP, 1'b0);
                     clear_link();
                     enter_mode(MODE_CONNECTED, EV_ACCEPTED);
                     put_plain(ACT_T3_START, 1'b0);
                  end
               end else if (u == U_DM) begin
                  if (pf) begin
                     put_plain(ACT_T1_STOP, 1'b0);
                     enter_mode(MODE_DISC, EV_PEER_REJECT);
                  end
               end else if (u == U_DISC) put_plain(ACT_DM, pf);
            end
         end
         MODE_DISCONNECTING: begin
            if (!is_u) begin
               if (pf) put_plain(ACT_DM, 1'b1);
            end else if (u == U_SABM || u == U_SABME) put_plain(ACT_DM, pf);
            else if (u == U_DISC) put_plain(ACT_UA, pf);
            else if (u == U_UA) begin
               if (pf) begin
                  put_plain(ACT_T1_STOP, 1'b0);
                  enter_mode(MODE_DISC, EV_DISC_DONE);
               end
            end else if (u == U_DM) begin
               if (pf) begin
                  put_plain(ACT_T1_STOP, 1'b0);
                  enter_mode(MODE_DISC, EV_PEER_REJECT);
               end
            end
         end
         MODE_CONNECTED: run_connected(h.addr, h.lbusy, h.t2run);
         MODE_FRMR: begin
            if (is_u && u == U_SABM) take_sabm(pf);
         end
         default: ;
      endcase
      if (step_actions.size() > 0) step_actions[step_actions.size()-1].last_action = 1'b1;
   endfunction

   function automatic void add_row(logic [7:0] addr, logic [7:0] ctrl, logic [11:0] len,
                                   logic [2:0] flags, int n, action_type first);
      header_type h;
      h.addr = addr; h.ctrl = ctrl; h.len = len;
      {h.lbusy, h.t2run, h.t3run} = flags;
      h.n_actions = n;
      h.first_action = first;
      directed_rows.push_back(h);
   endfunction

   function automatic logic [7:0] pick_uframe(logic pf);
      logic [7:0] codes[12];
      codes = '{U_SABM, U_DISC, U_UA, U_DM, U_FRMR, U_UI, U_TEST, U_SNRM, U_SABME,
                U_SNRME, U_SARME, U_XID};
      return codes[$urandom_range(0, 11)] | {3'b000, pf, 4'b0000};
   endfunction

   // mostly well-formed traffic for the current link state, some noise
   function automatic header_type random_header();
      header_type h;
      int r, p;
      logic pf;
      logic [2:0] nr, ns;
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 9);
      pf = $urandom_range(0, 1);
      h.addr = (p < 5) ? own_addr : (p < 8) ? partner_addr : 8'($urandom);
      nr = ($urandom_range(0, 99) < 92) ? va : 3'($urandom);
      ns = ($urandom_range(0, 99) < 85) ? vr : 3'($urandom);
      if (lk_mode != MODE_CONNECTED) begin
         if (r < 60) h.ctrl = U_SABM | {3'b000, pf, 4'b0000};
         else if (r < 80) h.ctrl = pick_uframe(pf);
         else h.ctrl = 8'($urandom);
      end else if (r < 50) h.ctrl = {nr, pf, ns, 1'b0};
      else if (r < 75) h.ctrl = {nr, pf, 2'($urandom), 2'b01};
      else if (r < 88) h.ctrl = pick_uframe(pf);
      else h.ctrl = 8'($urandom);
      p = $urandom_range(0, 9);
      h.len = (p == 0) ? 12'hFFF : (p == 1) ? 12'd0 : 12'($urandom_range(0, 4095));
      h.lbusy = $urandom_range(0, 3) == 0;
      h.t2run = $urandom_range(0, 1);
      h.t3run = $urandom_range(0, 1);
      h.n_actions = -1;
      h.first_action = ACT_UA;
      return h;
   endfunction

   // called at a rising edge; returns at the edge that takes the word
   task automatic send_header(header_type h);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      predict_header(h);
      if (h.n_actions >= 0 && (step_actions.size() != h.n_actions ||
          (h.n_actions > 0 && step_actions[0].action != h.first_action))) begin
         fail_count++;
         $display("directed header ctrl %h: predicted %0d actions, table says %0d",
                  h.ctrl, step_actions.size(), h.n_actions);
      end
      foreach (step_actions[i]) pending_actions.push_back(step_actions[i]);
      req_bus.valid <= 1'b1;
      req_bus.frame_address <= h.addr;
      req_bus.control_byte <= h.ctrl;
      req_bus.info_length <= h.len;
      req_bus.local_busy_flag <= h.lbusy;
      req_bus.t2_running <= h.t2run;
      req_bus.t3_running <= h.t3run;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      headers_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_actions.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // one write, then a wait with the enable low before the next write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OWN_ADDR) own_addr = val;
      else if (idx == CSR_PARTNER_ADDR) partner_addr = val;
      else if (idx == CSR_WINDOW_LIMIT) win_limit = val[2:0];
      @(posedge clock);
   endtask

   task automatic random_phase(int n, logic [7:0] own, logic [7:0] partner,
                               logic [7:0] win, bit hold_off);
      write_reg(CSR_OWN_ADDR, own);
      write_reg(CSR_PARTNER_ADDR, partner);
      write_reg(CSR_WINDOW_LIMIT, win);
      for (int i = 0; i < n; i++) begin
         // sender holds off until everything in flight has come back
         if (hold_off && i == n / 2) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending_actions.size() > 0) @(posedge clock);
         end
         send_header(random_header());
      end
      drain();
   endtask

   // result side: random stalls, in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_type got, want;
            got.action = action_type'(rsp_bus.action);
            got.poll_final = rsp_bus.poll_final;
            got.send_seq = rsp_bus.send_seq;
            got.recv_seq = rsp_bus.recv_seq;
            got.rejected_control = rsp_bus.rejected_control;
            got.frmr_flags = rsp_bus.frmr_flags;
            got.event_code = rsp_bus.event_code;
            got.link_mode = mode_type'(rsp_bus.link_mode);
            got.payload_length = rsp_bus.payload_length;
            got.last_action = rsp_bus.last_action;
            words_seen++;
            if (pending_actions.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: act %0d ev %0d mode %0d", got.action,
                           got.event_code, got.link_mode);
            end else begin
               want = pending_actions.pop_front();
               if (got !== want) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"word %0d mismatch\n  exp act %0d pf %b ns %0d nr %0d rc %h",
                               " fl %h ev %0d mode %0d len %0d last %b\n",
                               "  got act %0d pf %b ns %0d nr %0d rc %h fl %h ev %0d",
                               " mode %0d len %0d last %b"}, words_seen,
                              want.action, want.poll_final, want.send_seq, want.recv_seq,
                              want.rejected_control, want.frmr_flags, want.event_code,
                              want.link_mode, want.payload_length, want.last_action,
                              got.action, got.poll_final, got.send_seq, got.recv_seq,
                              got.rejected_control, got.frmr_flags, got.event_code,
                              got.link_mode, got.payload_length, got.last_action);
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.frame_address = '0;
      req_bus.control_byte = '0;
      req_bus.info_length = '0;
      req_bus.local_busy_flag = 1'b0;
      req_bus.t2_running = 1'b0;
      req_bus.t3_running = 1'b0;
      cycle_count = 0;
      fail_count = 0; mismatch_count = 0; words_seen = 0; headers_sent = 0;
      send_idle_pct = 25; recv_idle_pct = 67;
      lk_mode = MODE_DISC;
      vs = 3'd0; va = 3'd0; vr = 3'd0; rej_pend = 1'b0; peer_bsy = 1'b0;
      own_addr = 8'd1; partner_addr = 8'd3; win_limit = 3'd7;

      // after reset: own 1, partner 3
      add_row(8'h01, 8'h00, 12'd5,    3'b000, 0, ACT_UA);      // I while disconnected
      add_row(8'h01, 8'h53, 12'd0,    3'b000, 1, ACT_UA);      // DISC with poll
      add_row(8'hFF, 8'h03, 12'hFFF,  3'b111, 1, ACT_DELIVER); // UI, longest payload
      add_row(8'h01, 8'h93, 12'd0,    3'b000, 1, ACT_DM);      // SNRM
      add_row(8'h00, 8'h3F, 12'd0,    3'b000, 6, ACT_T1_STOP); // SABM with poll
      add_row(8'h03, 8'h00, 12'd17,   3'b001, -1, ACT_UA);     // in-sequence I, t3 running
      add_row(8'h03, 8'h12, 12'd9,    3'b100, -1, ACT_UA);     // I with poll, local busy
      add_row(8'h03, 8'h0C, 12'd1,    3'b010, -1, ACT_UA);     // out of sequence -> REJ
      add_row(8'h03, 8'h1A, 12'd1,    3'b000, -1, ACT_UA);     // again while rejecting
      add_row(8'h01, 8'h11, 12'd0,    3'b000, -1, ACT_UA);     // RR command with poll
      add_row(8'h03, 8'h05, 12'd0,    3'b000, -1, ACT_UA);     // RNR, peer busy on
      add_row(8'h03, 8'h19, 12'd0,    3'b000, -1, ACT_UA);     // REJ response with final
      add_row(8'h01, 8'h1D, 12'd0,    3'b000, -1, ACT_UA);     // SREJ
      add_row(8'h01, 8'hF3, 12'd300,  3'b000, -1, ACT_UA);     // TEST command echo
      add_row(8'h03, 8'hE3, 12'd0,    3'b000, -1, ACT_UA);     // TEST response
      add_row(8'h01, 8'h7F, 12'd0,    3'b000, -1, ACT_UA);     // SABME -> DM
      add_row(8'h01, 8'h0F, 12'd0,    3'b000, 4, ACT_T1_STOP); // DM / SARM shared code
      add_row(8'h01, 8'h2F, 12'd0,    3'b000, 6, ACT_T1_STOP); // SABM
      add_row(8'h01, 8'hBF, 12'd0,    3'b000, 4, ACT_FRMR);    // XID, unknown -> FRMR W
      add_row(8'h01, 8'h00, 12'd0,    3'b000, 0, ACT_UA);      // ignored in FRMR
      add_row(8'h01, 8'h2F, 12'd0,    3'b000, 6, ACT_T1_STOP); // SABM recovers
      add_row(8'h01, 8'hA0, 12'd0,    3'b000, 4, ACT_FRMR);    // bad N(R) -> FRMR Z
      add_row(8'h01, 8'h3F, 12'd0,    3'b000, 6, ACT_T1_STOP); // SABM
      add_row(8'h01, 8'h97, 12'd0,    3'b000, 4, ACT_T1_STOP); // FRMR received
      add_row(8'h01, 8'h2F, 12'd0,    3'b000, 6, ACT_T1_STOP); // SABM
      add_row(8'h01, 8'h43, 12'd0,    3'b000, 5, ACT_T1_STOP); // DISC -> disconnected

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_header(directed_rows[i]);
      drain();

      random_phase(50, 8'd1, 8'd3, 8'd7, 1'b0);
      send_idle_pct = 67; recv_idle_pct = 25;
      random_phase(50, 8'hFF, 8'h00, 8'd1, 1'b1);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(50, 8'h00, 8'hFF, 8'd0, 1'b0);

      if (pending_actions.size() > 0) begin
         fail_count++;
         $display("%0d action words never arrived", pending_actions.size());
      end
      $display("%0d headers sent, %0d action words checked, %0d mismatches",
               headers_sent, words_seen, mismatch_count);
      $display("covered link setup/teardown, sequencing, REJ, busy, TEST and FRMR paths");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== hdlc_abm_link_frame_handler.f =====
rtl/lfh_pkg.sv
rtl/lfh_ifs.sv
rtl/lfh_front.sv
rtl/lfh_back.sv
rtl/hdlc_abm_link_frame_handler.sv
dv/tb_hdlc_abm_link_frame_handler.sv
